FILE: src/ustr_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
package ustr_pkg;

  localparam int unsigned COUNT_BITS = 16;
  localparam int unsigned MAX_W      = 16;
  localparam int unsigned CMP_W      = (COUNT_BITS > MAX_W) ? COUNT_BITS : MAX_W;
  localparam int unsigned CP_W       = 21;
  localparam int unsigned FIFO_DEPTH = 4;
  localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);
  localparam int unsigned FCNT_W     = $clog2(FIFO_DEPTH + 1);

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [MAX_W-1:0]      max_t;
  typedef logic [CMP_W-1:0]      cmp_t;
  typedef logic [CP_W-1:0]       cp_t;

  localparam logic [7:0] NulByte    = 8'h00;
  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] Lead2Mask  = 8'h1F;
  localparam logic [7:0] Lead3Mask  = 8'h0F;
  localparam logic [7:0] Lead4Mask  = 8'h07;
  localparam logic [7:0] ContMask   = 8'h3F;
  localparam max_t       MaxReset   = 16'hFFFF;

  typedef struct packed {
    cp_t  code_point;
    logic bad_sequence;
    logic end_of_string;
    logic terminator_fits;
  } ustr_res_t;

  // Up to two results produced by one input byte; num counts them.
  typedef struct packed {
    logic [1:0] num;
    ustr_res_t  res0;
    ustr_res_t  res1;
  } ustr_step_t;

endpackage

FILE: src/ustr_step.sv
// Next-state and result logic for one input byte of the decoder.
module ustr_step (
  input  logic [7:0]             in_byte_i,
  input  logic [1:0]             rem_i,
  input  ustr_pkg::cp_t          pv_i,
  input  ustr_pkg::count_t       cnt_i,
  input  ustr_pkg::max_t         max_chars_i,
  output ustr_pkg::ustr_step_t   step_o,
  output logic [1:0]             rem_o,
  output ustr_pkg::cp_t          pv_o,
  output ustr_pkg::count_t       cnt_o
);
  import ustr_pkg::*;

  localparam count_t CountCap = '1;

  count_t cnt_bump;
  logic   cap_hit;
  cp_t    pv_shift;
  logic [1:0] rem_dec;

  always_comb begin
    cnt_bump = (cnt_i == CountCap) ? cnt_i : cnt_i + count_t'(1);
    cap_hit  = cmp_t'(cnt_i) >= cmp_t'(max_chars_i);
    pv_shift = {pv_i[CP_W-7:0], in_byte_i[5:0] & ContMask[5:0]};
    rem_dec  = rem_i - 2'd1;

    step_o = '0;
    rem_o  = rem_i;
    pv_o   = pv_i;
    cnt_o  = cnt_i;

    if (in_byte_i == NulByte) begin
      // The terminator closes the string; an open sequence is reported first.
      if (rem_i != 2'd0) begin
        step_o.num                   = 2'd2;
        step_o.res0.bad_sequence     = 1'b1;
        step_o.res1.end_of_string    = 1'b1;
        step_o.res1.terminator_fits  = cmp_t'(cnt_bump) < cmp_t'(max_chars_i);
      end else begin
        step_o.num                   = 2'd1;
        step_o.res0.end_of_string    = 1'b1;
        step_o.res0.terminator_fits  = ~cap_hit;
      end
      rem_o = 2'd0;
      pv_o  = '0;
      cnt_o = '0;
    end else if (rem_i != 2'd0) begin
      rem_o = rem_dec;
      if (rem_dec == 2'd0) begin
        step_o.num             = 2'd1;
        step_o.res0.code_point = pv_shift;
        cnt_o                  = cnt_bump;
        pv_o                   = '0;
      end else begin
        pv_o = pv_shift;
      end
    end else if (!cap_hit) begin
      priority if (in_byte_i < AsciiLimit) begin
        step_o.num             = 2'd1;
        step_o.res0.code_point = cp_t'(in_byte_i);
        cnt_o                  = cnt_bump;
      end else if (in_byte_i[7:5] == 3'b110) begin
        pv_o  = cp_t'(in_byte_i & Lead2Mask);
        rem_o = 2'd1;
      end else if (in_byte_i[7:4] == 4'b1110) begin
        pv_o  = cp_t'(in_byte_i & Lead3Mask);
        rem_o = 2'd2;
      end else if (in_byte_i[7:3] == 5'b11110) begin
        pv_o  = cp_t'(in_byte_i & Lead4Mask);
        rem_o = 2'd3;
      end else begin
        // Stray continuation byte or a lead byte for five or more bytes.
        step_o.num               = 2'd1;
        step_o.res0.bad_sequence = 1'b1;
        cnt_o                    = cnt_bump;
      end
    end
  end

endmodule

FILE: src/ustr_fifo.sv
// Small result queue taking up to two results per cycle and giving one.
module ustr_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [1:0]           wr_num_i,
  input  ustr_pkg::ustr_res_t  wr0_i,
  input  ustr_pkg::ustr_res_t  wr1_i,
  input  logic                 rd_i,
  output logic                 valid_o,
  output ustr_pkg::ustr_res_t  data_o,
  output logic                 space2_o
);
  import ustr_pkg::*;

  ustr_res_t         mem_q [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0]  rd_ptr_q, rd_ptr_d;
  logic [FCNT_W-1:0] cnt_q, cnt_d;
  logic [PTR_W-1:0]  wr_ptr_next;

  always_comb begin
    wr_ptr_next = wr_ptr_q + PTR_W'(1);
    wr_ptr_d    = wr_ptr_q + PTR_W'(wr_num_i);
    rd_ptr_d    = rd_ptr_q + PTR_W'(rd_i);
    cnt_d       = cnt_q + FCNT_W'(wr_num_i) - FCNT_W'(rd_i);
  end

  always_ff @(posedge clk_i) begin
    if (wr_num_i != 2'd0) begin
      mem_q[wr_ptr_q] <= wr0_i;
    end
    if (wr_num_i == 2'd2) begin
      mem_q[wr_ptr_next] <= wr1_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  assign valid_o  = cnt_q != '0;
  assign data_o   = mem_q[rd_ptr_q];
  assign space2_o = cnt_q <= FCNT_W'(FIFO_DEPTH - 2);

endmodule

FILE: src/utf8_stream_decoder.sv
// Top level of the UTF-8 byte stream to code point decoder.
// Each result is registered in the result queue and offered from its head.
// Throughput: one byte per cycle while the result queue has room for two results;
// a zero byte that cuts an open sequence yields two results.
// Reset: asynchronous, active low; clears decode state and the result queue and
// sets max_chars to 65535.
module utf8_stream_decoder (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration: max_chars.
  input  logic        cfg_wen_i,
  input  logic [15:0] cfg_wdata_i,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [20:0] code_point, [23:21] zero
  output logic [1:0]  m_axis_tuser,   // [0] bad_sequence, [1] terminator_fits
  output logic        m_axis_tlast    // end_of_string
);
  import ustr_pkg::*;

  // Decode state: bytes still expected, the value built so far, and the
  // number of characters given for the current string.
  logic [1:0] rem_q, rem_d;
  cp_t        pv_q, pv_d;
  count_t     cnt_q, cnt_d;
  max_t       max_chars_q;

  ustr_step_t step;
  ustr_res_t  head;
  logic       in_acc;
  logic       out_acc;
  logic       space2;

  // A request is taken whenever the queue has room for the two results the
  // worst-case byte can produce; this depends only on registered state.
  assign s_axis_tready = space2;
  assign in_acc        = s_axis_tvalid & s_axis_tready;
  assign out_acc       = m_axis_tvalid & m_axis_tready;

  ustr_step u_step (
    .in_byte_i   (s_axis_tdata),
    .rem_i       (rem_q),
    .pv_i        (pv_q),
    .cnt_i       (cnt_q),
    .max_chars_i (max_chars_q),
    .step_o      (step),
    .rem_o       (rem_d),
    .pv_o        (pv_d),
    .cnt_o       (cnt_d)
  );

  ustr_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .wr_num_i (in_acc ? step.num : 2'd0),
    .wr0_i    (step.res0),
    .wr1_i    (step.res1),
    .rd_i     (out_acc),
    .valid_o  (m_axis_tvalid),
    .data_o   (head),
    .space2_o (space2)
  );

  // State only moves on an accepted byte.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      pv_q  <= '0;
      cnt_q <= '0;
    end else if (in_acc) begin
      rem_q <= rem_d;
      pv_q  <= pv_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_chars_q <= MaxReset;
    end else if (cfg_wen_i) begin
      max_chars_q <= cfg_wdata_i;
    end
  end

  assign m_axis_tdata = {3'b000, head.code_point};
  assign m_axis_tuser = {head.terminator_fits, head.bad_sequence};
  assign m_axis_tlast = head.end_of_string;

endmodule
